// File: rtl/sspr_pkg.sv
package sspr_pkg;

  // Field widths of the transaction ports.
  localparam int unsigned START_IN_W  = 48;
  localparam int unsigned COUNT_IN_W  = 24;
  localparam int unsigned START_OUT_W = 48;
  localparam int unsigned CNT_OUT_W   = 25;

  // Configuration register widths and port layout.
  localparam int unsigned LB_W      = 14;
  localparam int unsigned G_W       = 16;
  localparam int unsigned PB_W      = 14;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Derived widths: bytes per logical group, physical blocks per group,
  // bytes per physical group and the in-group byte offsets of both maps.
  localparam int unsigned LGB_W  = LB_W + G_W;
  localparam int unsigned IOPT_W = LGB_W;
  localparam int unsigned DGB_W  = PB_W + IOPT_W;
  localparam int unsigned OFF1_W = LGB_W + 1;
  localparam int unsigned OFF2_W = DGB_W + 1;

  // Latency of the split multiplier.
  localparam int unsigned MUL_LAT = 2;

  localparam logic [LB_W-1:0]      LB_RESET    = LB_W'(520);
  localparam logic [G_W-1:0]       G_RESET     = G_W'(64);
  localparam logic [PB_W-1:0]      PB_RESET    = PB_W'(512);
  localparam logic [CNT_OUT_W-1:0] OUT_CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LB = 2'd0,
    REG_G  = 2'd1,
    REG_PB = 2'd2
  } cfg_reg_e;

endpackage

// File: rtl/sspr_div.sv
module sspr_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  // One quotient bit per stage; the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Restoring step: bring down the next bit and subtract if it fits.
    assign trial = {rem_in, num_in[NW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      num_q[k] <= {num_in[NW-2:0], take};
      rem_q[k] <= take ? DW'(trial - {1'b0, den_in}) : DW'(trial);
    end

    if (k < NW - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = num_q[NW-1];
  assign rem_o = rem_q[NW-1];

endmodule

// File: rtl/sspr_mul.sv
module sspr_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 30
) (
  input  logic          clk_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW-1:0] p_o
);

  localparam int unsigned HW = (AW + 1) / 2;
  localparam int unsigned LW = AW - HW;

  logic [HW+BW-1:0] lo_q;
  logic [LW+BW-1:0] hi_q;
  logic [AW-1:0]    p_q;

  // First stage forms two half-width partial products, the second adds them
  // modulo the address width.
  always_ff @(posedge clk_i) begin
    lo_q <= (HW+BW)'(a_i[HW-1:0]) * (HW+BW)'(b_i);
    hi_q <= (LW+BW)'(a_i[AW-1:HW]) * (LW+BW)'(b_i);
    p_q  <= AW'(lo_q) + AW'({hi_q, {HW{1'b0}}});
  end

  assign p_o = p_q;

endmodule

// File: rtl/sspr_delay.sv
module sspr_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // Plain shift line that keeps side data level with a datapath unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        tap_q[i] <= '0;
      end
    end else begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

// File: rtl/sector_size_pre_read_range.sv
// The path from accepted start to done_o runs through the four bit-per-stage
// divider segments in series.
// Throughput: one transaction per cycle; busy stays low and the result strobe
// cannot be held off, so the pipeline never stalls.
// Reset clears every valid bit and loads the registers with 520, 64 and 512.
module sector_size_pre_read_range #(
  parameter int unsigned ADDRESS_WIDTH = 48,
  parameter int unsigned COUNT_WIDTH   = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [sspr_pkg::START_IN_W-1:0]    start_block_i,
  input  logic [sspr_pkg::COUNT_IN_W-1:0]    block_count_i,
  input  logic                               cfg_we_i,
  input  logic [sspr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sspr_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic                               done_o,
  output logic [sspr_pkg::START_OUT_W-1:0]   pre_read_start_o,
  output logic [sspr_pkg::CNT_OUT_W-1:0]     pre_read_count_o,
  output logic                               needs_pre_read_o
);

  import sspr_pkg::*;

  localparam int unsigned AW = ADDRESS_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;

  // Configuration registers, with a zero write taken as one.
  logic [LB_W-1:0]  lb_q;
  logic [G_W-1:0]   g_q;
  logic [PB_W-1:0]  pb_q;
  logic [LGB_W-1:0] lgb_q;
  logic [LB_W-1:0]  wr_lb;
  logic [G_W-1:0]   wr_g;
  logic [PB_W-1:0]  wr_pb;

  assign wr_lb = cfg_wdata_i[LB_W-1:0];
  assign wr_g  = cfg_wdata_i[G_W-1:0];
  assign wr_pb = cfg_wdata_i[PB_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= LB_RESET;
      g_q  <= G_RESET;
      pb_q <= PB_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LB:  lb_q <= (wr_lb == '0) ? LB_W'(1) : wr_lb;
        REG_G:   g_q  <= (wr_g == '0) ? G_W'(1) : wr_g;
        REG_PB:  pb_q <= (wr_pb == '0) ? PB_W'(1) : wr_pb;
        default: ;
      endcase
    end
  end

  // Bytes per logical group are registered from the configuration registers.
  always_ff @(posedge clk_i) begin
    lgb_q <= LGB_W'(lb_q) * LGB_W'(g_q);
  end

  assign busy = 1'b0;

  // Stage 0: capture the request and clamp a zero count.
  logic [CW-1:0] cnt_in;
  logic [CW-1:0] cnt_nz;
  logic          v0_q;
  logic [AW-1:0] st0_q;
  logic [CW-1:0] cn0_q;
  logic [CW-1:0] cm0_q;

  assign cnt_in = CW'(block_count_i);
  assign cnt_nz = (cnt_in == '0) ? CW'(1) : cnt_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    st0_q <= AW'(start_block_i);
    cn0_q <= cnt_nz;
    cm0_q <= cnt_nz - CW'(1);
  end

  // Stage 1: exclusive end and last block of the request.
  logic          v1_q;
  logic [AW-1:0] st1_q;
  logic [CW-1:0] cn1_q;
  logic [AW-1:0] ex1_q;
  logic [AW-1:0] em1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q <= st0_q;
    cn1_q <= cn0_q;
    ex1_q <= st0_q + AW'(cn0_q);
    em1_q <= st0_q + AW'(cm0_q);
  end

  // Segment A: split start and end by the logical group, and work out the
  // physical blocks per group alongside.
  logic [AW-1:0]   qst_a;
  logic [G_W-1:0]  rst_a;
  logic [G_W-1:0]  rex_a;
  logic [AW-1:0]   qem_a;
  logic [G_W-1:0]  rem_a;
  logic [AW-1:0]   qlg_a;
  logic [PB_W-1:0] rlg_a;
  logic            va;
  logic [AW-1:0]   sta;
  logic [CW-1:0]   cna;

  sspr_div #(.NW(AW), .DW(G_W)) u_div_st (
    .clk_i(clk_i), .num_i(st1_q), .den_i(g_q), .quo_o(qst_a), .rem_o(rst_a)
  );
  sspr_div #(.NW(AW), .DW(G_W)) u_div_ex (
    .clk_i(clk_i), .num_i(ex1_q), .den_i(g_q), .quo_o(), .rem_o(rex_a)
  );
  sspr_div #(.NW(AW), .DW(G_W)) u_div_em (
    .clk_i(clk_i), .num_i(em1_q), .den_i(g_q), .quo_o(qem_a), .rem_o(rem_a)
  );
  sspr_div #(.NW(AW), .DW(PB_W)) u_div_lg (
    .clk_i(clk_i), .num_i(AW'(lgb_q)), .den_i(pb_q), .quo_o(qlg_a), .rem_o(rlg_a)
  );
  sspr_delay #(.W(1 + AW + CW), .N(AW)) u_dly_a (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .d_i({v1_q, st1_q, cn1_q}), .q_o({va, sta, cna})
  );

  // Stage B: alignment checks and choice of the candidate range.
  logic s_al;
  logic e_al;
  logic              vb_q;
  logic [AW-1:0]     stb_q;
  logic [CW-1:0]     cnb_q;
  logic              byb_q;
  logic [AW-1:0]     rsq_b_q;
  logic [G_W-1:0]    rsr_b_q;
  logic [AW-1:0]     req_b_q;
  logic [G_W-1:0]    rer_b_q;
  logic [IOPT_W-1:0] iopt_b_q;

  assign s_al = (rst_a == '0);
  assign e_al = (rex_a == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va;
    end
  end

  always_ff @(posedge clk_i) begin
    stb_q    <= sta;
    cnb_q    <= cna;
    byb_q    <= s_al & e_al;
    rsq_b_q  <= s_al ? qem_a : qst_a;
    rsr_b_q  <= s_al ? rem_a : rst_a;
    req_b_q  <= e_al ? qst_a : qem_a;
    rer_b_q  <= e_al ? rst_a : rem_a;
    iopt_b_q <= IOPT_W'(qlg_a) + IOPT_W'(rlg_a != '0);
  end

  // Stage C: byte offsets in the logical group and physical group size.
  logic              vc_q;
  logic [AW-1:0]     stc_q;
  logic [CW-1:0]     cnc_q;
  logic              byc_q;
  logic [AW-1:0]     rsq_c_q;
  logic [AW-1:0]     req_c_q;
  logic [IOPT_W-1:0] iopt_c_q;
  logic [LGB_W-1:0]  offf_c_q;
  logic [LGB_W-1:0]  offl_c_q;
  logic [DGB_W-1:0]  dgb_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    stc_q    <= stb_q;
    cnc_q    <= cnb_q;
    byc_q    <= byb_q;
    rsq_c_q  <= rsq_b_q;
    req_c_q  <= req_b_q;
    iopt_c_q <= iopt_b_q;
    offf_c_q <= LGB_W'(rsr_b_q) * LGB_W'(lb_q);
    offl_c_q <= LGB_W'(rer_b_q) * LGB_W'(lb_q);
    dgb_c_q  <= DGB_W'(pb_q) * DGB_W'(iopt_b_q);
  end

  // Stage D: end-of-block rule for the last block, including the pad region.
  logic [OFF1_W-1:0] lst1;
  logic              fit1;
  logic              vd_q;
  logic [AW-1:0]     std_q;
  logic [CW-1:0]     cnd_q;
  logic              byd_q;
  logic              padd_q;
  logic [AW-1:0]     rsq_d_q;
  logic [AW-1:0]     req_d_q;
  logic [IOPT_W-1:0] iopt_d_q;
  logic [OFF1_W-1:0] offf_d_q;
  logic [OFF1_W-1:0] offu_d_q;

  assign lst1 = OFF1_W'(offl_c_q) + OFF1_W'(lb_q) - OFF1_W'(1);
  assign fit1 = DGB_W'(lst1) <= dgb_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    std_q    <= stc_q;
    cnd_q    <= cnc_q;
    byd_q    <= byc_q;
    padd_q   <= !fit1 && (DGB_W'(lgb_q) > dgb_c_q);
    rsq_d_q  <= rsq_c_q;
    req_d_q  <= req_c_q;
    iopt_d_q <= iopt_c_q;
    offf_d_q <= OFF1_W'(offf_c_q);
    offu_d_q <= fit1 ? lst1 : OFF1_W'(offl_c_q);
  end

  // Segment E: physical block within the group, and group base addresses.
  logic [OFF1_W-1:0] qff_e;
  logic [OFF1_W-1:0] qfl_e;
  logic [AW-1:0]     ps_m;
  logic [AW-1:0]     pe_m;
  logic [AW-1:0]     ps_me;
  logic [AW-1:0]     pe_me;
  logic              ve;
  logic [AW-1:0]     ste;
  logic [CW-1:0]     cne;
  logic              bye;
  logic              pade;
  logic [IOPT_W-1:0] iopte;

  sspr_div #(.NW(OFF1_W), .DW(PB_W)) u_div_ff (
    .clk_i(clk_i), .num_i(offf_d_q), .den_i(pb_q), .quo_o(qff_e), .rem_o()
  );
  sspr_div #(.NW(OFF1_W), .DW(PB_W)) u_div_fl (
    .clk_i(clk_i), .num_i(offu_d_q), .den_i(pb_q), .quo_o(qfl_e), .rem_o()
  );
  sspr_mul #(.AW(AW), .BW(IOPT_W)) u_mul_fs (
    .clk_i(clk_i), .a_i(rsq_d_q), .b_i(iopt_d_q), .p_o(ps_m)
  );
  sspr_mul #(.AW(AW), .BW(IOPT_W)) u_mul_fe (
    .clk_i(clk_i), .a_i(req_d_q), .b_i(iopt_d_q), .p_o(pe_m)
  );
  sspr_delay #(.W(2 * AW), .N(OFF1_W - MUL_LAT)) u_dly_em (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i({ps_m, pe_m}), .q_o({ps_me, pe_me})
  );
  sspr_delay #(.W(3 + AW + CW + IOPT_W), .N(OFF1_W)) u_dly_e (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .d_i({vd_q, std_q, cnd_q, byd_q, padd_q, iopt_d_q}),
    .q_o({ve, ste, cne, bye, pade, iopte})
  );

  // Stage F: physical start and end blocks.
  logic              vf_q;
  logic [AW-1:0]     stf_q;
  logic [CW-1:0]     cnf_q;
  logic              byf_q;
  logic [IOPT_W-1:0] ioptf_q;
  logic [AW-1:0]     psf_q;
  logic [AW-1:0]     pef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= ve;
    end
  end

  always_ff @(posedge clk_i) begin
    stf_q   <= ste;
    cnf_q   <= cne;
    byf_q   <= bye;
    ioptf_q <= iopte;
    psf_q   <= ps_me + AW'(qff_e);
    pef_q   <= pade ? pe_me + AW'(iopte) - AW'(1) : pe_me + AW'(qfl_e);
  end

  // Segment G: split the physical range by the physical group.
  logic [AW-1:0]     qbs;
  logic [IOPT_W-1:0] rbs;
  logic [AW-1:0]     qbe;
  logic [IOPT_W-1:0] rbe;
  logic              vgd;
  logic [AW-1:0]     stgd;
  logic [CW-1:0]     cngd;
  logic              bygd;
  logic [IOPT_W-1:0] ioptgd;

  sspr_div #(.NW(AW), .DW(IOPT_W)) u_div_bs (
    .clk_i(clk_i), .num_i(psf_q), .den_i(ioptf_q), .quo_o(qbs), .rem_o(rbs)
  );
  sspr_div #(.NW(AW), .DW(IOPT_W)) u_div_be (
    .clk_i(clk_i), .num_i(pef_q), .den_i(ioptf_q), .quo_o(qbe), .rem_o(rbe)
  );
  sspr_delay #(.W(2 + AW + CW + IOPT_W), .N(AW)) u_dly_g (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .d_i({vf_q, stf_q, cnf_q, byf_q, ioptf_q}),
    .q_o({vgd, stgd, cngd, bygd, ioptgd})
  );

  // Stage G: register the split.
  logic              vg_q;
  logic [AW-1:0]     stg_q;
  logic [CW-1:0]     cng_q;
  logic              byg_q;
  logic [IOPT_W-1:0] ioptg_q;
  logic [AW-1:0]     qbs_g_q;
  logic [IOPT_W-1:0] rbs_g_q;
  logic [AW-1:0]     qbe_g_q;
  logic [IOPT_W-1:0] rbe_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else begin
      vg_q <= vgd;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q   <= stgd;
    cng_q   <= cngd;
    byg_q   <= bygd;
    ioptg_q <= ioptgd;
    qbs_g_q <= qbs;
    rbs_g_q <= rbs;
    qbe_g_q <= qbe;
    rbe_g_q <= rbe;
  end

  // Logical group bases for the mapped-back range, from the split multipliers.
  logic [AW-1:0] os_m;
  logic [AW-1:0] oe_m;

  sspr_mul #(.AW(AW), .BW(G_W)) u_mul_bs (
    .clk_i(clk_i), .a_i(qbs_g_q), .b_i(g_q), .p_o(os_m)
  );
  sspr_mul #(.AW(AW), .BW(G_W)) u_mul_be (
    .clk_i(clk_i), .a_i(qbe_g_q), .b_i(g_q), .p_o(oe_m)
  );

  // Stage H: byte offsets in the physical group.
  logic             vh_q;
  logic [AW-1:0]    sth_q;
  logic [CW-1:0]    cnh_q;
  logic             byh_q;
  logic [DGB_W-1:0] offs_h_q;
  logic [DGB_W-1:0] offl_h_q;
  logic [DGB_W-1:0] dgb_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else begin
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sth_q    <= stg_q;
    cnh_q    <= cng_q;
    byh_q    <= byg_q;
    offs_h_q <= DGB_W'(rbs_g_q) * DGB_W'(pb_q);
    offl_h_q <= DGB_W'(rbe_g_q) * DGB_W'(pb_q);
    dgb_h_q  <= DGB_W'(pb_q) * DGB_W'(ioptg_q);
  end

  // Stage I: end-of-block rule on the way back to logical blocks.
  logic [OFF2_W-1:0] lst2;
  logic              fit2;
  logic              vi_q;
  logic [AW-1:0]     sti_q;
  logic [CW-1:0]     cni_q;
  logic              byi_q;
  logic              padi_q;
  logic [OFF2_W-1:0] offs_i_q;
  logic [OFF2_W-1:0] offu_i_q;

  assign lst2 = OFF2_W'(offl_h_q) + OFF2_W'(pb_q) - OFF2_W'(1);
  assign fit2 = lst2 <= OFF2_W'(lgb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
    end else begin
      vi_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sti_q    <= sth_q;
    cni_q    <= cnh_q;
    byi_q    <= byh_q;
    padi_q   <= !fit2 && (dgb_h_q > DGB_W'(lgb_q));
    offs_i_q <= OFF2_W'(offs_h_q);
    offu_i_q <= fit2 ? lst2 : OFF2_W'(offl_h_q);
  end

  // Segment J: logical block within the group.
  logic [OFF2_W-1:0] qos;
  logic [OFF2_W-1:0] qoe;
  logic [AW-1:0]     os_mj;
  logic [AW-1:0]     oe_mj;
  logic              vjd;
  logic [AW-1:0]     stjd;
  logic [CW-1:0]     cnjd;
  logic              byjd;
  logic              padjd;

  sspr_div #(.NW(OFF2_W), .DW(LB_W)) u_div_os (
    .clk_i(clk_i), .num_i(offs_i_q), .den_i(lb_q), .quo_o(qos), .rem_o()
  );
  sspr_div #(.NW(OFF2_W), .DW(LB_W)) u_div_oe (
    .clk_i(clk_i), .num_i(offu_i_q), .den_i(lb_q), .quo_o(qoe), .rem_o()
  );
  sspr_delay #(.W(2 * AW), .N(OFF2_W)) u_dly_jm (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i({os_m, oe_m}), .q_o({os_mj, oe_mj})
  );
  sspr_delay #(.W(3 + AW + CW), .N(OFF2_W)) u_dly_j (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .d_i({vi_q, sti_q, cni_q, byi_q, padi_q}),
    .q_o({vjd, stjd, cnjd, byjd, padjd})
  );

  // Stage J: logical start and end of the pre-read range.
  logic          vj_q;
  logic [AW-1:0] stj_q;
  logic [CW-1:0] cnj_q;
  logic          byj_q;
  logic [AW-1:0] osj_q;
  logic [AW-1:0] oej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vj_q <= 1'b0;
    end else begin
      vj_q <= vjd;
    end
  end

  always_ff @(posedge clk_i) begin
    stj_q <= stjd;
    cnj_q <= cnjd;
    byj_q <= byjd;
    osj_q <= os_mj + AW'(qos);
    oej_q <= padjd ? oe_mj + AW'(g_q) - AW'(1) : oe_mj + AW'(qoe);
  end

  // Output register: saturated count, or the request itself when aligned.
  logic [AW-1:0]          span;
  logic                   sat;
  logic                   done_q;
  logic [START_OUT_W-1:0] ostart_q;
  logic [CNT_OUT_W-1:0]   ocount_q;
  logic                   oneed_q;

  assign span = oej_q - osj_q;
  assign sat  = (oej_q < osj_q) || (span >= AW'(OUT_CNT_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vj_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byj_q) begin
      ostart_q <= START_OUT_W'(stj_q);
      ocount_q <= CNT_OUT_W'(cnj_q);
      oneed_q  <= 1'b0;
    end else begin
      ostart_q <= START_OUT_W'(osj_q);
      ocount_q <= sat ? OUT_CNT_MAX : CNT_OUT_W'(span + AW'(1));
      oneed_q  <= 1'b1;
    end
  end

  assign done_o           = done_q;
  assign pre_read_start_o = ostart_q;
  assign pre_read_count_o = ocount_q;
  assign needs_pre_read_o = oneed_q;

endmodule
